>>> rtl/core/mck_pkg.sv
// Shared types, microcode encoding and Morse glyph table for the keyer core.
`timescale 1ns / 1ps

package mck_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t STEP_FETCH    = 3'd0;
    localparam step_t STEP_DISPATCH = 3'd1;
    localparam step_t STEP_MARK     = 3'd2;
    localparam step_t STEP_SPACE_EL = 3'd3;
    localparam step_t STEP_GAP      = 3'd4;
    localparam step_t STEP_CHKSP    = 3'd5;
    localparam step_t STEP_WORD     = 3'd6;

    localparam int DOT_W = 10;
    localparam int DUR_W = 13;
    localparam logic [DOT_W-1:0] DOT_RESET = 10'd100;
    localparam logic [DOT_W-1:0] DOT_MAX   = 10'd1000;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'd26;

    typedef enum logic [1:0] {
        DUR_UNIT,   // one dot time
        DUR_ELEM,   // one or three, by current element
        DUR_X3,
        DUR_X7
    } dur_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_ELEM,
        COND_MORE_ELEM,
        COND_NOT_SPACE
    } cond_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        logic     lamp;
        dur_sel_t dur;
        logic     last;
        logic     shift;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    typedef struct packed {
        logic no_elem;
        logic more_elem;
        logic not_space;
        logic out_free;
    } status_t;

    // pat bit 0 is the first element; 1 = dash
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } glyph_t;

    function automatic glyph_t mck_glyph(input logic [5:0] slot);
        glyph_t g;
        case (slot)
            6'd0:  g = '{len: 3'd2, pat: 5'b00010}; // a
            6'd1:  g = '{len: 3'd4, pat: 5'b00001}; // b
            6'd2:  g = '{len: 3'd4, pat: 5'b00101}; // c
            6'd3:  g = '{len: 3'd3, pat: 5'b00001}; // d
            6'd4:  g = '{len: 3'd1, pat: 5'b00000}; // e
            6'd5:  g = '{len: 3'd4, pat: 5'b00100}; // f
            6'd6:  g = '{len: 3'd3, pat: 5'b00011}; // g
            6'd7:  g = '{len: 3'd4, pat: 5'b00000}; // h
            6'd8:  g = '{len: 3'd2, pat: 5'b00000}; // i
            6'd9:  g = '{len: 3'd4, pat: 5'b01110}; // j
            6'd10: g = '{len: 3'd3, pat: 5'b00101}; // k
            6'd11: g = '{len: 3'd4, pat: 5'b00010}; // l
            6'd12: g = '{len: 3'd2, pat: 5'b00011}; // m
            6'd13: g = '{len: 3'd2, pat: 5'b00001}; // n
            6'd14: g = '{len: 3'd3, pat: 5'b00111}; // o
            6'd15: g = '{len: 3'd4, pat: 5'b00110}; // p
            6'd16: g = '{len: 3'd4, pat: 5'b01011}; // q
            6'd17: g = '{len: 3'd3, pat: 5'b00010}; // r
            6'd18: g = '{len: 3'd3, pat: 5'b00000}; // s
            6'd19: g = '{len: 3'd1, pat: 5'b00001}; // t
            6'd20: g = '{len: 3'd3, pat: 5'b00100}; // u
            6'd21: g = '{len: 3'd4, pat: 5'b01000}; // v
            6'd22: g = '{len: 3'd3, pat: 5'b00110}; // w
            6'd23: g = '{len: 3'd4, pat: 5'b01001}; // x
            6'd24: g = '{len: 3'd4, pat: 5'b01101}; // y
            6'd25: g = '{len: 3'd4, pat: 5'b00011}; // z
            6'd26: g = '{len: 3'd5, pat: 5'b11111}; // 0
            6'd27: g = '{len: 3'd5, pat: 5'b11110}; // 1
            6'd28: g = '{len: 3'd5, pat: 5'b11100}; // 2
            6'd29: g = '{len: 3'd5, pat: 5'b11000}; // 3
            6'd30: g = '{len: 3'd5, pat: 5'b10000}; // 4
            6'd31: g = '{len: 3'd5, pat: 5'b00000}; // 5
            6'd32: g = '{len: 3'd5, pat: 5'b00001}; // 6
            6'd33: g = '{len: 3'd5, pat: 5'b00011}; // 7
            6'd34: g = '{len: 3'd5, pat: 5'b00111}; // 8
            6'd35: g = '{len: 3'd5, pat: 5'b01111}; // 9
            default: g = '{len: 3'd0, pat: 5'b00000};
        endcase
        return g;
    endfunction

    // Unknown codes give an empty glyph
    function automatic glyph_t mck_lookup(input logic [7:0] ch);
        logic [7:0] lc;
        logic [7:0] off;
        glyph_t     g;
        lc  = ch;
        off = 8'd0;
        g   = '{len: 3'd0, pat: 5'b00000};
        if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            lc = ch | CASE_BIT;
        end
        if (lc inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            off = lc - CH_LOWER_A;
            g   = mck_glyph(off[5:0]);
        end else if (lc inside {[CH_ZERO:CH_NINE]}) begin
            off = lc - CH_ZERO + DIGIT_BASE;
            g   = mck_glyph(off[5:0]);
        end
        return g;
    endfunction

endpackage

>>> rtl/core/mck_ucode_rom.sv
// Control store: one microcode word per program step.
`timescale 1ns / 1ps

module mck_ucode_rom (
    input  mck_pkg::step_t  step,
    output mck_pkg::ucode_t uword
);
    import mck_pkg::*;

    always_comb begin
        uword = '{load: 1'b0, emit: 1'b0, lamp: 1'b0, dur: DUR_UNIT, last: 1'b0,
                  shift: 1'b0, cond: COND_NEVER, target: STEP_FETCH};
        case (step)
            STEP_FETCH: begin
                uword.load   = 1'b1;
                uword.cond   = COND_NO_INPUT;
                uword.target = STEP_FETCH;
            end
            STEP_DISPATCH: begin
                uword.cond   = COND_NO_ELEM;
                uword.target = STEP_CHKSP;
            end
            STEP_MARK: begin
                uword.emit = 1'b1;
                uword.lamp = 1'b1;
                uword.dur  = DUR_ELEM;
            end
            STEP_SPACE_EL: begin
                uword.emit   = 1'b1;
                uword.shift  = 1'b1;
                uword.cond   = COND_MORE_ELEM;
                uword.target = STEP_MARK;
            end
            STEP_GAP: begin
                uword.emit   = 1'b1;
                uword.dur    = DUR_X3;
                uword.last   = 1'b1;
                uword.cond   = COND_ALWAYS;
                uword.target = STEP_FETCH;
            end
            STEP_CHKSP: begin
                uword.cond   = COND_NOT_SPACE;
                uword.target = STEP_GAP;
            end
            STEP_WORD: begin
                uword.emit   = 1'b1;
                uword.dur    = DUR_X7;
                uword.cond   = COND_ALWAYS;
                uword.target = STEP_GAP;
            end
            default: begin
                uword.cond   = COND_ALWAYS;
                uword.target = STEP_FETCH;
            end
        endcase
    end

endmodule

>>> rtl/core/mck_datapath.sv
// Keyer datapath: dot time register, glyph shifter, duration scaling, output register.
`timescale 1ns / 1ps

module mck_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [mck_pkg::DOT_W-1:0]   cfg_data,
    input  mck_pkg::ucode_t             uword,
    input  logic                        load,
    input  logic                        fire,
    input  logic [7:0]                  s_char,
    input  logic                        m_tready,
    output mck_pkg::status_t            status,
    output logic                        m_tvalid,
    output logic [mck_pkg::DUR_W-1:0]   m_dur,
    output logic                        m_lamp,
    output logic                        m_last
);
    import mck_pkg::*;

    logic [DOT_W-1:0] dot_len_reg;
    logic [DOT_W-1:0] unit_reg, unit_next;
    logic [2:0]       cnt_reg;
    logic [4:0]       pat_reg;
    logic             space_reg;
    glyph_t           glyph;
    logic [DUR_W-1:0] unit_w, unit3, unit7, dur;
    logic             valid_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             lamp_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_len_reg <= DOT_RESET;
        end else if (cfg_we) begin
            dot_len_reg <= cfg_data;
        end
    end

    // zero acts as one, above range saturates
    always_comb begin
        if (dot_len_reg == '0) begin
            unit_next = {{(DOT_W-1){1'b0}}, 1'b1};
        end else if (dot_len_reg > DOT_MAX) begin
            unit_next = DOT_MAX;
        end else begin
            unit_next = dot_len_reg;
        end
    end

    assign glyph = mck_lookup(s_char);

    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg  <= unit_next;
            cnt_reg   <= glyph.len;
            pat_reg   <= glyph.pat;
            space_reg <= (s_char == CH_SPACE);
        end else if (fire && uword.shift) begin
            cnt_reg <= cnt_reg - 3'd1;
            pat_reg <= {1'b0, pat_reg[4:1]};
        end
    end

    assign unit_w = {{(DUR_W-DOT_W){1'b0}}, unit_reg};
    assign unit3  = {unit_w[DUR_W-2:0], 1'b0} + unit_w;
    assign unit7  = {unit_w[DUR_W-4:0], 3'b000} - unit_w;

    always_comb begin
        case (uword.dur)
            DUR_UNIT: dur = unit_w;
            DUR_ELEM: dur = pat_reg[0] ? unit3 : unit_w;
            DUR_X3:   dur = unit3;
            DUR_X7:   dur = unit7;
            default:  dur = unit_w;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            dur_reg  <= dur;
            lamp_reg <= uword.lamp;
            last_reg <= uword.last;
        end
    end

    assign status.no_elem   = (cnt_reg == 3'd0);
    assign status.more_elem = (cnt_reg > 3'd1);
    assign status.not_space = !space_reg;
    assign status.out_free  = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_dur    = dur_reg;
    assign m_lamp   = lamp_reg;
    assign m_last   = last_reg;

endmodule

>>> rtl/core/morse_character_keyer_core.sv
// Top level of the Morse keyer: step sequencer over the control store and datapath.
`timescale 1ns / 1ps

// Morse character keyer core.
// Slave stream: one ASCII character per request on s_tdata[7:0]. Letters of
// either case and digits are keyed out; a space gives a seven-unit dark
// segment; anything else gives only the closing gap.
// Master stream: one lamp segment per request. m_tuser is the lamp state,
// m_tdata[12:0] the length in ms, m_tlast marks the three-unit closing gap
// that ends every character.
// Config channel: cfg_data is the dot time in ms, always taken (cfg_ready
// high); write it only while idle. Zero is used as 1, above 1000 as 1000.
// Timing: a microprogram of seven steps. s_tready is high only in the
// fetch step. A glyph runs dispatch, mark and element space per element,
// closing gap, back to fetch; a space runs dispatch, check-space, word
// gap, closing gap; an unknown code dispatch, check-space, closing gap.
// m_tvalid rises when the first emitting step of that run fires.
// Each emitting step holds while the output register is full and
// m_tready is low, so a stall on the master side only stretches the run.
// Reset: dot time back to 100 ms, program counter to fetch, output empty.
module morse_character_keyer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,     // dot length in ms
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] character
    // segment stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [12:0] duration, [15:13] zero
    output logic        m_tuser,      // [0] lamp_on
    output logic        m_tlast       // closing letter gap
);
    import mck_pkg::*;

    step_t            step_reg, step_next;
    ucode_t           uword;
    status_t          status;
    logic             accept, fire, jump;
    logic [DUR_W-1:0] m_dur;

    mck_ucode_rom u_rom (
        .step  (step_reg),
        .uword (uword)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = uword.load;
    assign accept    = s_tvalid && s_tready;
    // an emitting step only executes when the output register can take it
    assign fire      = uword.emit && status.out_free;

    mck_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .uword    (uword),
        .load     (accept),
        .fire     (fire),
        .s_char   (s_tdata),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_dur    (m_dur),
        .m_lamp   (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(16-DUR_W){1'b0}}, m_dur};

    // branch condition mux
    always_comb begin
        case (uword.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_INPUT:  jump = !s_tvalid;
            COND_NO_ELEM:   jump = status.no_elem;
            COND_MORE_ELEM: jump = status.more_elem;
            COND_NOT_SPACE: jump = status.not_space;
            default:        jump = 1'b0;
        endcase
    end

    always_comb begin
        if (uword.emit && !status.out_free) begin
            step_next = step_reg;               // hold on back-pressure
        end else if (jump) begin
            step_next = uword.target;
        end else begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    // accepted character always moves on to dispatch
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (step_reg == STEP_DISPATCH))
        else $error("accept did not advance to dispatch");

    // closing gap ends the program run
    a_gap_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && uword.last) |=> (step_reg == STEP_FETCH))
        else $error("closing gap did not return to fetch");

    // a lit segment is never the closing gap
    a_lit_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tlast)
        else $error("lit segment flagged last");

    // program counter stays inside the program
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_WORD)
        else $error("step counter outside program");

endmodule

>>> bench/morse_keyer_checker.sv
// Segment predictor and scoreboard for the Morse keyer core, watching all three channels.
`timescale 1ns / 1ps

module morse_keyer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          error_count,
    output int          outstanding
);
    import mck_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        lamp_on;
        logic [12:0] duration;
        logic        last;
    } segment_t;

    segment_t   segment_q[$];
    logic [9:0] dot_ms;
    int         errors = 0;

    // dots and dashes of a letter or digit, empty for anything else
    function automatic string glyph_of(input logic [7:0] ch);
        logic [7:0] lc;
        string      g;
        lc = ch;
        g  = "";
        if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            lc = ch + 8'd32;
        end
        case (lc)
            "a": g = ".-";    "b": g = "-...";  "c": g = "-.-.";  "d": g = "-..";
            "e": g = ".";     "f": g = "..-.";  "g": g = "--.";   "h": g = "....";
            "i": g = "..";    "j": g = ".---";  "k": g = "-.-";   "l": g = ".-..";
            "m": g = "--";    "n": g = "-.";    "o": g = "---";   "p": g = ".--.";
            "q": g = "--.-";  "r": g = ".-.";   "s": g = "...";   "t": g = "-";
            "u": g = "..-";   "v": g = "...-";  "w": g = ".--";   "x": g = "-..-";
            "y": g = "-.--";  "z": g = "--..";
            "0": g = "-----"; "1": g = ".----"; "2": g = "..---"; "3": g = "...--";
            "4": g = "....-"; "5": g = "....."; "6": g = "-...."; "7": g = "--...";
            "8": g = "---.."; "9": g = "----.";
            default: g = "";
        endcase
        return g;
    endfunction

    function automatic void key_out(input logic [7:0] ch);
        logic [12:0] unit;
        logic [12:0] mark_ms;
        string       g;
        int          j;
        // zero is taken as one unit, anything past the maximum saturates
        if (dot_ms == 10'd0) begin
            unit = 13'd1;
        end else if (dot_ms > DOT_MAX) begin
            unit = 13'(DOT_MAX);
        end else begin
            unit = 13'(dot_ms);
        end
        g = glyph_of(ch);
        for (j = 0; j < g.len(); j++) begin
            mark_ms = (g[j] == "-") ? 13'(unit * 3) : unit;
            segment_q.push_back('{lamp_on: 1'b1, duration: mark_ms, last: 1'b0});
            segment_q.push_back('{lamp_on: 1'b0, duration: unit, last: 1'b0});
        end
        if (ch == CH_SPACE) begin
            segment_q.push_back('{lamp_on: 1'b0, duration: 13'(unit * 7), last: 1'b0});
        end
        segment_q.push_back('{lamp_on: 1'b0, duration: 13'(unit * 3), last: 1'b1});
    endfunction

    always @(posedge aclk) begin
        segment_t exp_seg;
        if (!aresetn) begin
            dot_ms = DOT_RESET;
            segment_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                dot_ms = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (segment_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t: unexpected segment lamp=%b dur=%0d last=%b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                    end
                end else begin
                    exp_seg = segment_q.pop_front();
                    if (m_tuser !== exp_seg.lamp_on || m_tlast !== exp_seg.last ||
                        m_tdata !== {3'b000, exp_seg.duration}) begin
                        errors++;
                        if (errors <= REPORT_LIMIT) begin
                            $display("%0t: segment mismatch exp lamp=%b dur=%0d last=%b, got lamp=%b dur=%0d last=%b",
                                     $realtime, exp_seg.lamp_on, exp_seg.duration,
                                     exp_seg.last, m_tuser, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                key_out(s_tdata);
            end
        end
        error_count <= errors;
        outstanding <= segment_q.size();
    end

endmodule

>>> bench/morse_character_keyer_core_test.sv
// Stimulus and verdict for the Morse keyer core: directed and random characters over several dot times.
`timescale 1ns / 1ps

module morse_character_keyer_core_test;

    import mck_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run
    localparam int SETTLE_CYCLES = 20;      // longer than a five-element glyph
    localparam int LONG_HOLD     = 400;     // receiver hold-off, fills the core
    localparam int PHASE_CHARS   = 26;
    localparam int FLOOD_CHARS   = 25;

    typedef logic [7:0] char_q_t[$];

    // receiver stall patterns
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_RARE_STALL,
        SINK_WINDOW
    } sink_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [9:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int error_count;
    int outstanding;
    bit hold_req = 1'b0;    // asks the receiver for one long hold-off

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    morse_character_keyer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    morse_keyer_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Mostly letters and digits so glyph sequencing gets most of the run;
    // spaces and raw codes across the full byte range fill the rest.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return CH_LOWER_A + 8'($urandom_range(0, 25));
        end else if (pick < 60) begin
            return CH_UPPER_A + 8'($urandom_range(0, 25));
        end else if (pick < 75) begin
            return CH_ZERO + 8'($urandom_range(0, 9));
        end else if (pick < 85) begin
            return CH_SPACE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One config request; the core only sees this while idle.
    task automatic write_unit_ms(input logic [9:0] ms);
        cfg_valid <= 1'b1;
        cfg_data  <= ms;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer characters in bursts. tvalid stays high across a burst and is
    // dropped only when a real gap follows.
    task automatic send_chars(input char_q_t chars, input bit with_gaps);
        int burst_left;
        int i;
        burst_left = $urandom_range(1, 10);
        for (i = 0; i < chars.size(); i++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= chars[i];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if (with_gaps) begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom_range(0, 255));
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Sender pause: every predicted segment back, then let the sequencer
    // return to fetch before anything else touches the core.
    task automatic wait_drain();
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stall patterns in spans, with no-stall spans mixed
    // in. The long hold-off is counted here, independent of the sender.
    initial begin : sink
        sink_mode_t mode;
        int         span;
        int         k;
        m_tready <= 1'b0;
        forever begin
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (k = 0; k < span; k++) begin
                @(posedge aclk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    SINK_OPEN:       m_tready <= 1'b1;
                    SINK_COIN:       m_tready <= 1'($urandom_range(0, 1));
                    SINK_RARE_STALL: m_tready <= ($urandom_range(0, 7) != 0);
                    default:         m_tready <= ((k % 6) < 2);
                endcase
            end
        end
    end

    // Hard stop if the core wedges.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("morse_character_keyer_core test failed");
        $finish;
    end

    initial begin : stimulus
        char_q_t    chars;
        logic [9:0] dot_plan[7];
        int         p;
        int         n;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 10'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed set at the reset dot time: both ends of each letter
        // range in both cases, digit ends, space, a dash-only and a dot-only
        // glyph, and unknown codes hugging every range edge plus 0x00/0xFF.
        chars = '{"A", "Z", "a", "z", "0", "9", " ", "E", "T", "J", "Q", "5",
                  8'h00, 8'hFF, 8'h80, 8'h7F, 8'h1F,
                  8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A};
        send_chars(chars, 1'b1);
        wait_drain();

        // Dot time sweep: minimum, maximum, zero taken as one, values past
        // the maximum that saturate, then two random legal settings.
        dot_plan[0] = 10'd1;
        dot_plan[1] = DOT_MAX;
        dot_plan[2] = 10'd0;
        dot_plan[3] = 10'd1023;
        dot_plan[4] = 10'd1001;
        dot_plan[5] = 10'($urandom_range(1, 1000));
        dot_plan[6] = 10'($urandom_range(1, 1000));

        for (p = 0; p < 7; p++) begin
            write_unit_ms(dot_plan[p]);
            chars.delete();
            for (n = 0; n < PHASE_CHARS; n++) begin
                chars.push_back(random_char());
            end
            // roughly one phase in three runs back to back with no gaps
            send_chars(chars, $urandom_range(0, 2) != 0);
            wait_drain();
        end

        // Flood: receiver holds off while requests keep coming, so the
        // output register fills and s_tready stays low until it lets go.
        write_unit_ms(10'($urandom_range(1, 1000)));
        chars.delete();
        for (n = 0; n < FLOOD_CHARS; n++) begin
            chars.push_back(random_char());
        end
        hold_req = 1'b1;
        send_chars(chars, 1'b0);
        wait_drain();

        if (error_count == 0 && outstanding == 0) begin
            $display("morse_character_keyer_core test passed");
        end else begin
            $display("morse_character_keyer_core test failed");
        end
        $finish;
    end

endmodule
